>>> sv/usbdfu_pkg.sv
`timescale 1ns / 1ps
package usbdfu_pkg;

    localparam logic [3:0] PH_APP_DETACH = 4'd1;
    localparam logic [3:0] PH_IDLE       = 4'd2;
    localparam logic [3:0] PH_DN_SYNC    = 4'd3;
    localparam logic [3:0] PH_DN_BUSY    = 4'd4;
    localparam logic [3:0] PH_DN_IDLE    = 4'd5;
    localparam logic [3:0] PH_MAN_SYNC   = 4'd6;
    localparam logic [3:0] PH_MAN        = 4'd7;
    localparam logic [3:0] PH_MAN_WAIT   = 4'd8;
    localparam logic [3:0] PH_ERROR      = 4'd10;

    localparam logic [3:0] ERR_OK    = 4'd0;
    localparam logic [3:0] ERR_ERASE = 4'd4;
    localparam logic [3:0] ERR_PROG  = 4'd6;

    localparam logic [2:0] IND_READY     = 3'd0;
    localparam logic [2:0] IND_CONNECTED = 3'd1;
    localparam logic [2:0] IND_WRITING   = 3'd2;
    localparam logic [2:0] IND_DONE      = 3'd3;
    localparam logic [2:0] IND_FAULT     = 3'd4;

    localparam logic [1:0] FUNC_SETUP = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_TXD   = 2'd2;
    localparam logic [1:0] FUNC_RESET = 2'd3;

    localparam logic [7:0] CREQ_DETACH    = 8'd0;
    localparam logic [7:0] CREQ_DNLOAD    = 8'd1;
    localparam logic [7:0] CREQ_GETSTATUS = 8'd3;
    localparam logic [7:0] CREQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] CREQ_GETSTATE  = 8'd5;
    localparam logic [7:0] CREQ_ABORT     = 8'd6;

    localparam logic [7:0] SREQ_GET_STATUS = 8'h00;
    localparam logic [7:0] SREQ_SET_ADDR   = 8'h05;
    localparam logic [7:0] SREQ_GET_DESC   = 8'h06;
    localparam logic [7:0] SREQ_GET_CONFIG = 8'h08;
    localparam logic [7:0] SREQ_SET_CONFIG = 8'h09;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    localparam logic [15:0] PAGE_BYTES = 16'd1024;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ZLP   = 3'd1,
        KIND_BYTE  = 3'd2,
        KIND_STALL = 3'd3,
        KIND_FLASH = 3'd4,
        KIND_ADDR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        SRC_SINGLE = 3'd0,
        SRC_DEV    = 3'd1,
        SRC_CFG    = 3'd2,
        SRC_STR    = 3'd3,
        SRC_STATUS = 3'd4,
        SRC_ZERO   = 3'd5
    } src_t;

    typedef struct packed {
        src_t        src;
        logic [2:0]  str_sel;
        logic [5:0]  count;
        kind_t       skind;
        logic [7:0]  sbyte;
        logic [6:0]  saddr;
        logic        flash_en;
        logic [15:0] flash_block;
        logic [15:0] flash_len;
        logic [3:0]  err;
        logic [3:0]  phase;
        logic [2:0]  led;
    } job_t;

    localparam logic [7:0] DEV_ROM [0:17] = '{
        8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'h83, 8'h04,
        8'h11, 8'hDF, 8'h00, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1
    };

    localparam logic [7:0] CFG_ROM [0:26] = '{
        8'd9, 8'd2, 8'd27, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd0, 8'hFE, 8'h01, 8'h02, 8'd4,
        8'd9, 8'h21, 8'h0B, 8'hFF, 8'h00, 8'h00, 8'h04, 8'h1A, 8'h01
    };

    localparam logic [5:0] STR_LEN [0:4] = '{6'd4, 6'd28, 6'd32, 6'd10, 6'd26};

    localparam logic [7:0] STR_CHARS [0:4][0:14] = '{
        '{8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h6C, 8'h61, 8'h73, 8'h68, 8'h46, 8'h6C, 8'h6F,
          8'h70, 8'h70, 8'h79, 8'h2D, 8'h4F, 8'h00, 8'h00},
        '{8'h44, 8'h46, 8'h55, 8'h20, 8'h42, 8'h6F, 8'h6F, 8'h74,
          8'h6C, 8'h6F, 8'h61, 8'h64, 8'h65, 8'h72, 8'h00},
        '{8'h31, 8'h2E, 8'h30, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h40, 8'h46, 8'h6C, 8'h61, 8'h73, 8'h68, 8'h20, 8'h2F,
          8'h30, 8'h78, 8'h30, 8'h38, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic [7:0] str_byte(input logic [2:0] sel, input logic [4:0] idx);
        logic [4:0] off;
        logic [7:0] res;
        off = idx - 5'd2;
        if (idx == 5'd0)
        begin
            res = {2'b00, STR_LEN[sel]};
        end
        else if (idx == 5'd1)
        begin
            res = 8'd3;
        end
        else if (sel == 3'd0)
        begin
            res = STR_CHARS[0][{3'b000, idx[0]}];
        end
        else if (idx[0])
        begin
            res = 8'd0;
        end
        else
        begin
            res = STR_CHARS[sel][off[4:1]];
        end
        return res;
    endfunction

endpackage

>>> sv/usbdfu_in_if.sv
`timescale 1ns / 1ps
interface usbdfu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  req_type;
    logic [7:0]  request;
    logic [15:0] value;
    logic [15:0] length;
    logic [6:0]  rx_count;
    logic        erase_failed;
    logic        program_failed;

    modport source (output valid, func, req_type, request, value, length, rx_count,
                    erase_failed, program_failed, input ready);
    modport sink (input valid, func, req_type, request, value, length, rx_count,
                  erase_failed, program_failed, output ready);
endinterface

>>> sv/usbdfu_out_if.sv
`timescale 1ns / 1ps
interface usbdfu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] flash_block;
    logic [15:0] flash_len;
    logic [6:0]  device_address;
    logic [2:0]  led_mode;
    logic        last;

    modport source (output valid, kind, data_byte, flash_block, flash_len, device_address,
                    led_mode, last, input ready);
    modport sink (input valid, kind, data_byte, flash_block, flash_len, device_address,
                  led_mode, last, output ready);
endinterface

>>> sv/usbdfu_front.sv
`timescale 1ns / 1ps
module usbdfu_front (
    input  logic               clk,
    input  logic               rst_n,
    usbdfu_in_if.sink          in_ch,
    input  logic               q_full,
    output logic               push,
    output usbdfu_pkg::job_t   job
);
    import usbdfu_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  err_reg, err_next;
    logic [15:0] block_reg, block_next;
    logic [15:0] plen_reg, plen_next;
    logic [6:0]  paddr_reg, paddr_next;
    logic [6:0]  aaddr_reg, aaddr_next;
    logic [7:0]  cfg_reg, cfg_next;
    logic [2:0]  led_reg, led_next;
    logic [5:0]  dsize;
    logic [5:0]  dcount;
    logic        dvalid;
    src_t        dsrc;

    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    always_comb
    begin
        dvalid = 1'b1;
        dsrc = SRC_DEV;
        dsize = 6'd18;
        case (in_ch.value[15:8])
            DESC_DEVICE:
            begin
                dsrc = SRC_DEV;
                dsize = 6'd18;
            end
            DESC_CONFIG:
            begin
                dsrc = SRC_CFG;
                dsize = 6'd27;
            end
            DESC_STRING:
            begin
                dsrc = SRC_STR;
                dvalid = in_ch.value[7:0] < 8'd5;
                dsize = dvalid ? STR_LEN[in_ch.value[2:0]] : 6'd0;
            end
            default:
            begin
                dvalid = 1'b0;
            end
        endcase
        dcount = (in_ch.length < {10'd0, dsize}) ? in_ch.length[5:0] : dsize;
    end

    always_comb
    begin
        phase_next = phase_reg;
        err_next = err_reg;
        block_next = block_reg;
        plen_next = plen_reg;
        paddr_next = paddr_reg;
        aaddr_next = aaddr_reg;
        cfg_next = cfg_reg;
        led_next = led_reg;

        job = '0;
        job.src = SRC_SINGLE;
        job.count = 6'd1;
        job.skind = KIND_NONE;
        job.str_sel = in_ch.value[2:0];
        job.err = err_reg;
        job.phase = phase_reg;
        job.flash_block = block_reg;
        job.flash_len = (plen_reg > PAGE_BYTES) ? PAGE_BYTES : plen_reg;

        case (in_ch.func)
            FUNC_SETUP:
            begin
                if (in_ch.req_type[6:5] == 2'b01)
                begin
                    case (in_ch.request)
                        CREQ_GETSTATUS:
                        begin
                            job.src = SRC_STATUS;
                            job.count = 6'd6;
                            case (phase_reg)
                                PH_DN_SYNC: phase_next = PH_DN_BUSY;
                                PH_DN_BUSY:
                                begin
                                    led_next = IND_WRITING;
                                    phase_next = PH_DN_IDLE;
                                    if (plen_reg != 16'd0)
                                    begin
                                        job.flash_en = 1'b1;
                                        if (in_ch.erase_failed)
                                        begin
                                            phase_next = PH_ERROR;
                                            err_next = ERR_ERASE;
                                            led_next = IND_FAULT;
                                        end
                                        else if (in_ch.program_failed)
                                        begin
                                            phase_next = PH_ERROR;
                                            err_next = ERR_PROG;
                                            led_next = IND_FAULT;
                                        end
                                    end
                                end
                                PH_MAN_SYNC: phase_next = PH_MAN;
                                PH_MAN:
                                begin
                                    led_next = IND_DONE;
                                    phase_next = PH_MAN_WAIT;
                                end
                                default: phase_next = phase_reg;
                            endcase
                        end
                        CREQ_GETSTATE:
                        begin
                            job.skind = KIND_BYTE;
                            job.sbyte = {4'd0, phase_reg};
                        end
                        CREQ_CLRSTATUS:
                        begin
                            phase_next = PH_IDLE;
                            err_next = ERR_OK;
                            job.skind = KIND_ZLP;
                        end
                        CREQ_ABORT:
                        begin
                            phase_next = PH_IDLE;
                            job.skind = KIND_ZLP;
                        end
                        CREQ_DNLOAD:
                        begin
                            if (in_ch.length == 16'd0)
                            begin
                                phase_next = PH_MAN_SYNC;
                                job.skind = KIND_ZLP;
                            end
                            else
                            begin
                                block_next = in_ch.value;
                                plen_next = in_ch.length;
                                phase_next = PH_DN_SYNC;
                            end
                        end
                        CREQ_DETACH:
                        begin
                            phase_next = PH_APP_DETACH;
                            job.skind = KIND_ZLP;
                        end
                        default: job.skind = KIND_STALL;
                    endcase
                end
                else
                begin
                    case (in_ch.request)
                        SREQ_GET_DESC:
                        begin
                            if (!dvalid)
                            begin
                                job.skind = KIND_STALL;
                            end
                            else if (dcount == 6'd0)
                            begin
                                job.skind = KIND_ZLP;
                            end
                            else
                            begin
                                job.src = dsrc;
                                job.count = dcount;
                            end
                        end
                        SREQ_SET_ADDR:
                        begin
                            paddr_next = in_ch.value[6:0];
                            job.skind = KIND_ZLP;
                        end
                        SREQ_SET_CONFIG:
                        begin
                            cfg_next = in_ch.value[7:0];
                            led_next = IND_CONNECTED;
                            job.skind = KIND_ZLP;
                        end
                        SREQ_GET_CONFIG:
                        begin
                            job.skind = KIND_BYTE;
                            job.sbyte = cfg_reg;
                        end
                        SREQ_GET_STATUS:
                        begin
                            job.src = SRC_ZERO;
                            job.count = 6'd2;
                        end
                        default: job.skind = KIND_STALL;
                    endcase
                end
            end
            FUNC_DATA:
            begin
                if (phase_reg == PH_DN_SYNC && in_ch.rx_count != 7'd0)
                begin
                    plen_next = {9'd0, in_ch.rx_count};
                    job.skind = KIND_ZLP;
                end
            end
            FUNC_TXD:
            begin
                if (paddr_reg != 7'd0 && aaddr_reg == 7'd0)
                begin
                    aaddr_next = paddr_reg;
                    job.skind = KIND_ADDR;
                    job.saddr = paddr_reg;
                end
            end
            FUNC_RESET:
            begin
                paddr_next = 7'd0;
                aaddr_next = 7'd0;
                cfg_next = 8'd0;
                phase_next = PH_IDLE;
                err_next = ERR_OK;
            end
            default: job.skind = KIND_NONE;
        endcase
        job.led = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            err_reg <= ERR_OK;
            block_reg <= 16'd0;
            plen_reg <= 16'd0;
            paddr_reg <= 7'd0;
            aaddr_reg <= 7'd0;
            cfg_reg <= 8'd0;
            led_reg <= IND_READY;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            err_reg <= err_next;
            block_reg <= block_next;
            plen_reg <= plen_next;
            paddr_reg <= paddr_next;
            aaddr_reg <= aaddr_next;
            cfg_reg <= cfg_next;
            led_reg <= led_next;
        end
    end
endmodule

>>> sv/usbdfu_queue.sv
`timescale 1ns / 1ps
module usbdfu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  usbdfu_pkg::job_t   push_job,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output usbdfu_pkg::job_t   head
);
    import usbdfu_pkg::*;

    job_t       mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign head = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");
endmodule

>>> sv/usbdfu_back.sv
`timescale 1ns / 1ps
module usbdfu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  usbdfu_pkg::job_t   head,
    output logic               pop,
    usbdfu_out_if.source       out_ch
);
    import usbdfu_pkg::*;

    logic [5:0]  idx_reg;
    logic        valid_reg;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] block_reg;
    logic [15:0] len_reg;
    logic [6:0]  addr_reg;
    logic [2:0]  led_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;
    logic [6:0]  total;
    kind_t       kind_next;
    logic [7:0]  byte_next;

    assign load = q_valid && (!valid_reg || out_ch.ready);
    assign total = {1'b0, head.count} + {6'd0, head.flash_en};
    assign is_last = {1'b0, idx_reg} == total - 7'd1;
    assign pop = load && is_last;

    always_comb
    begin
        kind_next = KIND_BYTE;
        byte_next = 8'd0;
        if (idx_reg == head.count)
        begin
            kind_next = KIND_FLASH;
        end
        else
        begin
            case (head.src)
                SRC_SINGLE:
                begin
                    kind_next = head.skind;
                    byte_next = head.sbyte;
                end
                SRC_DEV:    byte_next = DEV_ROM[idx_reg[4:0]];
                SRC_CFG:    byte_next = CFG_ROM[idx_reg[4:0]];
                SRC_STR:    byte_next = str_byte(head.str_sel, idx_reg[4:0]);
                SRC_STATUS:
                begin
                    case (idx_reg[2:0])
                        3'd0:    byte_next = {4'd0, head.err};
                        3'd1:    byte_next = 8'd10;
                        3'd4:    byte_next = {4'd0, head.phase};
                        default: byte_next = 8'd0;
                    endcase
                end
                default:    byte_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            block_reg <= (kind_next == KIND_FLASH) ? head.flash_block : 16'd0;
            len_reg <= (kind_next == KIND_FLASH) ? head.flash_len : 16'd0;
            addr_reg <= head.saddr;
            led_reg <= head.led;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 6'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg <= is_last ? 6'd0 : idx_reg + 6'd1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.kind = kind_reg;
    assign out_ch.data_byte = byte_reg;
    assign out_ch.flash_block = block_reg;
    assign out_ch.flash_len = len_reg;
    assign out_ch.device_address = addr_reg;
    assign out_ch.led_mode = led_reg;
    assign out_ch.last = last_reg;

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_ch.valid && out_ch.last))
        else $error("job retired without a last word");
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 6'd0)
        else $error("word index not restarted");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_last) |=> idx_reg == $past(idx_reg) + 6'd1)
        else $error("word index did not advance");
endmodule

>>> sv/usb_dfu_control_endpoint.sv
// Each event's job is written into the two-entry job queue, and the back end registers each
// result word that it reads from the queue head. One result word leaves per cycle while
// out_ch.ready holds; an event yields one to thirty-two words, and the front takes a new
// event every cycle until the job queue is full.
// Reset (rst_n, asynchronous): DFU idle, status ok, all counters, addresses and queue cleared.
`timescale 1ns / 1ps
module usb_dfu_control_endpoint (
    input  logic         clk,
    input  logic         rst_n,
    usbdfu_in_if.sink    in_ch,
    usbdfu_out_if.source out_ch
);
    import usbdfu_pkg::*;

    job_t push_job;
    job_t head;
    logic push;
    logic full;
    logic pop;
    logic q_valid;

    usbdfu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (full),
        .push   (push),
        .job    (push_job)
    );

    usbdfu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    usbdfu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .out_ch  (out_ch)
    );
endmodule

>>> tb/sv/usb_dfu_control_endpoint_test.sv
`timescale 1ns / 1ps
module usb_dfu_control_endpoint_test;
    import usbdfu_pkg::*;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  req_type;
        logic [7:0]  request;
        logic [15:0] value;
        logic [15:0] length;
        logic [6:0]  rx_count;
        logic        erase_failed;
        logic        program_failed;
    } event_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] flash_block;
        logic [15:0] flash_len;
        logic [6:0]  device_address;
        logic [2:0]  led_mode;
        logic        last;
    } word_t;

    typedef struct {
        event_t ev;
        bit     fixed;
        kind_t  kind0;
        logic [7:0] byte0;
    } row_t;

    logic clk;
    logic rst_n;
    usbdfu_in_if in_ch();
    usbdfu_out_if out_ch();

    usb_dfu_control_endpoint uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    logic [3:0]  phase;
    logic [3:0]  err_code;
    logic [15:0] blk_num;
    logic [15:0] pend_len;
    logic [6:0]  pend_addr;
    logic [6:0]  act_addr;
    logic [7:0]  cfg_val;
    logic [2:0]  led;

    word_t expected_words[$];
    word_t new_words[$];
    int    mismatches;
    bit    calm;
    bit    hold_off;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report(input string what, input word_t got, input word_t exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        mismatches++;
    endtask

    function automatic logic [7:0] desc_byte(input int sel, input int str_idx, input int i);
        logic [7:0] r;
        r = 8'd0;
        if (sel == 1)
        begin
            r = DEV_ROM[i];
        end
        else if (sel == 2)
        begin
            r = CFG_ROM[i];
        end
        else if (i == 0)
        begin
            r = {2'b00, STR_LEN[str_idx]};
        end
        else if (i == 1)
        begin
            r = 8'd3;
        end
        else if (str_idx == 0)
        begin
            r = STR_CHARS[0][i - 2];
        end
        else if (i % 2 == 1)
        begin
            r = 8'd0;
        end
        else
        begin
            r = STR_CHARS[str_idx][(i - 2) / 2];
        end
        return r;
    endfunction

    function automatic void add_word(input kind_t k, input logic [7:0] b,
                                     input logic [15:0] fb, input logic [15:0] fl,
                                     input logic [6:0] a);
        word_t w;
        w = '0;
        w.kind = k;
        w.data_byte = b;
        w.flash_block = fb;
        w.flash_len = fl;
        w.device_address = a;
        new_words.push_back(w);
    endfunction

    function automatic void send_desc(input int sel, input int str_idx, input int sz,
                                      input int lim);
        int n;
        n = sz < lim ? sz : lim;
        if (n == 0)
        begin
            add_word(KIND_ZLP, 0, 0, 0, 0);
        end
        for (int i = 0; i < n; i++)
        begin
            add_word(KIND_BYTE, desc_byte(sel, str_idx, i), 0, 0, 0);
        end
    endfunction

    function automatic void endpoint_predict(input event_t ev);
        logic [7:0] dtype;
        logic [7:0] didx;
        new_words.delete();
        dtype = ev.value[15:8];
        didx = ev.value[7:0];
        if (ev.func == FUNC_SETUP && ev.req_type[6:5] == 2'b01)
        begin
            case (ev.request)
                CREQ_GETSTATUS:
                begin
                    add_word(KIND_BYTE, {4'd0, err_code}, 0, 0, 0);
                    add_word(KIND_BYTE, 8'd10, 0, 0, 0);
                    add_word(KIND_BYTE, 0, 0, 0, 0);
                    add_word(KIND_BYTE, 0, 0, 0, 0);
                    add_word(KIND_BYTE, {4'd0, phase}, 0, 0, 0);
                    add_word(KIND_BYTE, 0, 0, 0, 0);
                    if (phase == PH_DN_SYNC)
                    begin
                        phase = PH_DN_BUSY;
                    end
                    else if (phase == PH_DN_BUSY)
                    begin
                        led = IND_WRITING;
                        phase = PH_DN_IDLE;
                        if (pend_len > 0)
                        begin
                            add_word(KIND_FLASH, 0, blk_num,
                                     pend_len > PAGE_BYTES ? PAGE_BYTES : pend_len, 0);
                            if (ev.erase_failed)
                            begin
                                phase = PH_ERROR;
                                err_code = ERR_ERASE;
                                led = IND_FAULT;
                            end
                            else if (ev.program_failed)
                            begin
                                phase = PH_ERROR;
                                err_code = ERR_PROG;
                                led = IND_FAULT;
                            end
                        end
                    end
                    else if (phase == PH_MAN_SYNC)
                    begin
                        phase = PH_MAN;
                    end
                    else if (phase == PH_MAN)
                    begin
                        led = IND_DONE;
                        phase = PH_MAN_WAIT;
                    end
                end
                CREQ_GETSTATE: add_word(KIND_BYTE, {4'd0, phase}, 0, 0, 0);
                CREQ_CLRSTATUS:
                begin
                    phase = PH_IDLE;
                    err_code = ERR_OK;
                    add_word(KIND_ZLP, 0, 0, 0, 0);
                end
                CREQ_ABORT:
                begin
                    phase = PH_IDLE;
                    add_word(KIND_ZLP, 0, 0, 0, 0);
                end
                CREQ_DNLOAD:
                begin
                    if (ev.length == 0)
                    begin
                        phase = PH_MAN_SYNC;
                        add_word(KIND_ZLP, 0, 0, 0, 0);
                    end
                    else
                    begin
                        blk_num = ev.value;
                        pend_len = ev.length;
                        phase = PH_DN_SYNC;
                    end
                end
                CREQ_DETACH:
                begin
                    phase = PH_APP_DETACH;
                    add_word(KIND_ZLP, 0, 0, 0, 0);
                end
                default: add_word(KIND_STALL, 0, 0, 0, 0);
            endcase
        end
        else if (ev.func == FUNC_SETUP)
        begin
            case (ev.request)
                SREQ_GET_DESC:
                begin
                    if (dtype == DESC_DEVICE)
                    begin
                        send_desc(1, 0, 18, ev.length);
                    end
                    else if (dtype == DESC_CONFIG)
                    begin
                        send_desc(2, 0, 27, ev.length);
                    end
                    else if (dtype == DESC_STRING && didx < 5)
                    begin
                        send_desc(3, didx, STR_LEN[didx], ev.length);
                    end
                    else
                    begin
                        add_word(KIND_STALL, 0, 0, 0, 0);
                    end
                end
                SREQ_SET_ADDR:
                begin
                    pend_addr = ev.value[6:0];
                    add_word(KIND_ZLP, 0, 0, 0, 0);
                end
                SREQ_SET_CONFIG:
                begin
                    cfg_val = ev.value[7:0];
                    led = IND_CONNECTED;
                    add_word(KIND_ZLP, 0, 0, 0, 0);
                end
                SREQ_GET_CONFIG: add_word(KIND_BYTE, cfg_val, 0, 0, 0);
                SREQ_GET_STATUS:
                begin
                    add_word(KIND_BYTE, 0, 0, 0, 0);
                    add_word(KIND_BYTE, 0, 0, 0, 0);
                end
                default: add_word(KIND_STALL, 0, 0, 0, 0);
            endcase
        end
        else if (ev.func == FUNC_DATA)
        begin
            if (phase == PH_DN_SYNC && ev.rx_count > 0)
            begin
                pend_len = {9'd0, ev.rx_count};
                add_word(KIND_ZLP, 0, 0, 0, 0);
            end
        end
        else if (ev.func == FUNC_TXD)
        begin
            if (pend_addr != 0 && act_addr == 0)
            begin
                act_addr = pend_addr;
                add_word(KIND_ADDR, 0, 0, 0, act_addr);
            end
        end
        else
        begin
            pend_addr = 0;
            act_addr = 0;
            cfg_val = 0;
            phase = PH_IDLE;
            err_code = ERR_OK;
        end
        if (new_words.size() == 0)
        begin
            add_word(KIND_NONE, 0, 0, 0, 0);
        end
        foreach (new_words[i])
        begin
            new_words[i].led_mode = led;
            new_words[i].last = (i == new_words.size() - 1);
            expected_words.push_back(new_words[i]);
        end
    endfunction

    function automatic event_t mk(input logic [1:0] f, input logic [7:0] rt,
                                  input logic [7:0] rq, input logic [15:0] v,
                                  input logic [15:0] l, input logic [6:0] rx,
                                  input logic ef, input logic pf);
        event_t e;
        e.func = f;
        e.req_type = rt;
        e.request = rq;
        e.value = v;
        e.length = l;
        e.rx_count = rx;
        e.erase_failed = ef;
        e.program_failed = pf;
        return e;
    endfunction

    function automatic event_t random_event();
        event_t e;
        logic [63:0] rnd;
        int pick;
        rnd = {$urandom, $urandom};
        e = rnd[58:0];
        pick = $urandom_range(0, 11);
        if (pick < 7)
        begin
            e.func = FUNC_SETUP;
            e.req_type = ($urandom_range(0, 2) != 0) ? {e.req_type[7], 2'b01, e.req_type[4:0]}
                                                     : e.req_type;
            if (e.req_type[6:5] == 2'b01)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: e.request = CREQ_DNLOAD;
                    3, 4, 5: e.request = CREQ_GETSTATUS;
                    6: e.request = CREQ_GETSTATE;
                    7: e.request = CREQ_CLRSTATUS;
                    8: e.request = CREQ_ABORT;
                    default: e.request = ($urandom_range(0, 1) != 0) ? CREQ_DETACH : e.request;
                endcase
                if (e.request == CREQ_DNLOAD && $urandom_range(0, 3) == 0)
                begin
                    e.length = 16'd0;
                end
                else if (e.request == CREQ_DNLOAD && $urandom_range(0, 1) == 0)
                begin
                    e.length = 16'($urandom_range(1, 1100));
                end
                e.erase_failed = ($urandom_range(0, 7) == 0);
                e.program_failed = ($urandom_range(0, 5) == 0);
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0, 1: e.request = SREQ_GET_DESC;
                    2: e.request = SREQ_SET_ADDR;
                    3: e.request = SREQ_SET_CONFIG;
                    4: e.request = SREQ_GET_CONFIG;
                    5: e.request = SREQ_GET_STATUS;
                    default: e.request = e.request;
                endcase
                if (e.request == SREQ_GET_DESC && $urandom_range(0, 3) != 0)
                begin
                    e.value[15:8] = 8'($urandom_range(1, 3));
                    e.value[7:0] = 8'($urandom_range(0, 5));
                    e.length = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 40))
                                                           : e.length;
                end
            end
        end
        else if (pick < 9)
        begin
            e.func = FUNC_DATA;
            e.rx_count = 7'($urandom_range(0, 64));
        end
        else if (pick < 11)
        begin
            e.func = FUNC_TXD;
        end
        else
        begin
            e.func = FUNC_RESET;
        end
        return e;
    endfunction

    task automatic send_event(input event_t ev);
        in_ch.valid <= 1'b1;
        {in_ch.func, in_ch.req_type, in_ch.request, in_ch.value, in_ch.length,
         in_ch.rx_count, in_ch.erase_failed, in_ch.program_failed} <= ev;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        endpoint_predict(ev);
        if (!calm && !hold_off && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic run_table();
        row_t rows[$];
        row_t r;
        word_t first;
        word_t want;
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_GETSTATE, 0, 0, 0, 0, 0), 1, KIND_BYTE, 8'd2});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'h0100, 16'hFFFF, 0, 0, 0),
                         1, KIND_BYTE, 8'd18});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'h0200, 16'hFFFF, 0, 0, 0),
                         1, KIND_BYTE, 8'd9});
        for (int i = 0; i < 5; i++)
        begin
            rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'(16'h0300 + i), 40,
                                0, 0, 0), 0, KIND_NONE, 0});
        end
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'h0305, 40, 0, 0, 0),
                         1, KIND_STALL, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'hFF00, 40, 0, 0, 0),
                         1, KIND_STALL, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_DESC, 16'h0100, 0, 0, 0, 0),
                         1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h00, SREQ_SET_ADDR, 16'hFFFF, 0, 0, 0, 0),
                         1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_TXD, 0, 0, 0, 0, 0, 0, 0), 0, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_TXD, 0, 0, 0, 0, 0, 0, 0), 1, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h00, SREQ_SET_CONFIG, 16'h00FF, 0, 0, 0, 0),
                         1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_CONFIG, 0, 0, 0, 0, 0),
                         1, KIND_BYTE, 8'hFF});
        rows.push_back('{mk(FUNC_SETUP, 8'h80, SREQ_GET_STATUS, 0, 0, 0, 0, 0), 0, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'hFF, 8'hFF, 0, 0, 0, 0, 0), 1, KIND_STALL, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_DNLOAD, 16'hFFFF, 16'hFFFF, 0, 0, 0),
                         1, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_DATA, 0, 0, 0, 0, 7'd64, 0, 0), 1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_GETSTATUS, 0, 0, 0, 1, 1), 0, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_GETSTATUS, 0, 0, 0, 1, 1), 0, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_CLRSTATUS, 0, 0, 0, 0, 0), 1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_DNLOAD, 0, 0, 0, 0, 0), 1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_GETSTATUS, 0, 0, 0, 0, 0), 0, KIND_NONE, 0});
        rows.push_back('{mk(FUNC_SETUP, 8'h21, CREQ_DETACH, 0, 0, 0, 0, 0), 1, KIND_ZLP, 0});
        rows.push_back('{mk(FUNC_RESET, 0, 0, 0, 0, 0, 0, 0), 1, KIND_NONE, 0});
        foreach (rows[i])
        begin
            r = rows[i];
            send_event(r.ev);
            if (r.fixed)
            begin
                first = new_words[0];
                if (first.kind != r.kind0 || first.data_byte != r.byte0)
                begin
                    want = first;
                    want.kind = r.kind0;
                    want.data_byte = r.byte0;
                    report($sformatf("table row %0d", i), first, want);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        word_t got;
        word_t exp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.kind, out_ch.data_byte, out_ch.flash_block, out_ch.flash_len,
                   out_ch.device_address, out_ch.led_mode, out_ch.last};
            if (expected_words.size() == 0)
            begin
                report("unexpected word", got, '0);
            end
            else
            begin
                exp = expected_words.pop_front();
                if (got.kind != exp.kind) report("kind", got, exp);
                if (got.data_byte != exp.data_byte) report("data_byte", got, exp);
                if (got.flash_block != exp.flash_block) report("flash_block", got, exp);
                if (got.flash_len != exp.flash_len) report("flash_len", got, exp);
                if (got.device_address != exp.device_address) report("address", got, exp);
                if (got.led_mode != exp.led_mode) report("led_mode", got, exp);
                if (got.last != exp.last) report("last", got, exp);
            end
        end
    end

    initial
    begin
        int burst;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int guard;
        mismatches = 0;
        calm = 0;
        hold_off = 0;
        phase = PH_IDLE;
        err_code = ERR_OK;
        blk_num = 0;
        pend_len = 0;
        pend_addr = 0;
        act_addr = 0;
        cfg_val = 0;
        led = IND_READY;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.func, in_ch.req_type, in_ch.request, in_ch.value, in_ch.length,
         in_ch.rx_count, in_ch.erase_failed, in_ch.program_failed} = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_table();
        for (int n = 0; n < 205; n++)
        begin
            if (n == 60)
            begin
                hold_off = 1'b1;
            end
            if (n == 170)
            begin
                calm = 1'b1;
            end
            send_event(random_event());
        end
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_words.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (expected_words.size() == 0 && mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/usbdfu_pkg.sv
sv/usbdfu_in_if.sv
sv/usbdfu_out_if.sv
sv/usbdfu_front.sv
sv/usbdfu_queue.sv
sv/usbdfu_back.sv
sv/usb_dfu_control_endpoint.sv
tb/sv/usb_dfu_control_endpoint_test.sv
